FILE: src/pbm_pkg.sv
// Package for the peak bin max picker: payload structs, register indexes,
// controller states and the command/status bundles between the controller and datapath.
// No dependencies.
package pbm_pkg;

  localparam int unsigned IM_BINS   = 32;
  localparam int unsigned SLOT_W    = $clog2(IM_BINS);
  localparam int unsigned COUNT_W   = $clog2(IM_BINS + 1);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned STEP_W    = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MZ_LOWER     = 3'd0,
    REG_MZ_UPPER     = 3'd1,
    REG_MZ_BIN_WIDTH = 3'd2,
    REG_IM_LOWER     = 3'd3,
    REG_IM_UPPER     = 3'd4,
    REG_IM_BIN_WIDTH = 3'd5,
    REG_IM_BIN_COUNT = 3'd6,
    REG_USE_IM       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [23:0] spectrum_tag;
    logic [7:0]  charge;
    logic [31:0] mz;
    logic [31:0] intensity;
    logic [17:0] ion_mobility;
    logic        peak_present;
    logic        spectrum_end;
  } peak_in_t;

  typedef struct packed {
    logic [31:0] flat_bin;
    logic [23:0] entry_spectrum;
    logic [15:0] bin_offset;
    logic [7:0]  entry_charge;
    logic        last_of_run;
  } bin_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_MZ,
    S_DIV_OFF,
    S_DIV_IM,
    S_DECIDE,
    S_FLUSH_PRE,
    S_PLACE,
    S_END_CHK,
    S_FLUSH_END
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic start_mz;
    logic start_off;
    logic start_im;
    logic cap_bin;
    logic cap_off;
    logic cap_slot;
    logic place;
    logic emit;
    logic flush_end;
    logic finish_flush;
    logic close_bin;
  } cmd_t;

  typedef struct packed {
    logic mz_ok;
    logic im_ok;
    logic use_im;
    logic div_busy;
    logic slot_ok;
    logic need_pre;
    logic count_zero;
    logic idx_last;
    logic out_space;
    logic end_flag;
  } stat_t;

endpackage

FILE: src/pbm_div.sv
// Shift-subtract divider, one quotient bit per cycle, with a preset partial remainder.
// Depends on pbm_pkg.
module pbm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                rem_init_i,
  input  logic [31:0]                dividend_i,
  input  logic [31:0]                divisor_i,
  input  logic [pbm_pkg::STEP_W-1:0] steps_i,
  output logic                       busy_o,
  output logic [31:0]                quo_o,
  output logic [31:0]                rem_o
);

  logic [31:0]                rem_q, rem_d, quo_q, quo_d, dvd_q, dvd_d, dsr_q, dsr_d;
  logic [pbm_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [32:0]                trial;
  logic                       ge;

  assign trial = {rem_q, dvd_q[31]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvd_d = dvd_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = rem_init_i;
      quo_d = '0;
      dvd_d = dividend_i;
      dsr_d = divisor_i;
      cnt_d = steps_i;
    end else if (cnt_q != '0) begin
      rem_d = ge ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
      quo_d = {quo_q[30:0], ge};
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: src/pbm_ctrl.sv
// Controller state machine for the peak bin max picker.
// Depends on pbm_pkg; drives the datapath through cmd_t and reads stat_t.
module pbm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pbm_pkg::stat_t stat_i,
  output pbm_pkg::cmd_t  cmd_o
);

  pbm_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pbm_pkg::S_IDLE: begin
        if (in_valid_i) state_d = pbm_pkg::S_CHECK;
      end
      pbm_pkg::S_CHECK: begin
        if (stat_i.mz_ok && stat_i.im_ok) state_d = pbm_pkg::S_DIV_MZ;
        else                              state_d = pbm_pkg::S_END_CHK;
      end
      pbm_pkg::S_DIV_MZ: begin
        if (!stat_i.div_busy) state_d = pbm_pkg::S_DIV_OFF;
      end
      pbm_pkg::S_DIV_OFF: begin
        if (!stat_i.div_busy) state_d = stat_i.use_im ? pbm_pkg::S_DIV_IM : pbm_pkg::S_DECIDE;
      end
      pbm_pkg::S_DIV_IM: begin
        if (!stat_i.div_busy) state_d = pbm_pkg::S_DECIDE;
      end
      pbm_pkg::S_DECIDE: begin
        if (!stat_i.slot_ok)      state_d = pbm_pkg::S_END_CHK;
        else if (stat_i.need_pre) state_d = pbm_pkg::S_FLUSH_PRE;
        else                      state_d = pbm_pkg::S_PLACE;
      end
      pbm_pkg::S_FLUSH_PRE: begin
        if (stat_i.out_space && stat_i.idx_last) state_d = pbm_pkg::S_PLACE;
      end
      pbm_pkg::S_PLACE: begin
        state_d = stat_i.end_flag ? pbm_pkg::S_FLUSH_END : pbm_pkg::S_IDLE;
      end
      pbm_pkg::S_END_CHK: begin
        state_d = stat_i.end_flag ? pbm_pkg::S_FLUSH_END : pbm_pkg::S_IDLE;
      end
      pbm_pkg::S_FLUSH_END: begin
        if (stat_i.count_zero || (stat_i.out_space && stat_i.idx_last)) begin
          state_d = pbm_pkg::S_IDLE;
        end
      end
      default: state_d = pbm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pbm_pkg::S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.latch_in  = in_valid_i;
      end
      pbm_pkg::S_CHECK: begin
        cmd_o.start_mz = stat_i.mz_ok && stat_i.im_ok;
      end
      pbm_pkg::S_DIV_MZ: begin
        cmd_o.cap_bin   = !stat_i.div_busy;
        cmd_o.start_off = !stat_i.div_busy;
      end
      pbm_pkg::S_DIV_OFF: begin
        cmd_o.cap_off  = !stat_i.div_busy;
        cmd_o.start_im = !stat_i.div_busy && stat_i.use_im;
      end
      pbm_pkg::S_DIV_IM: begin
        cmd_o.cap_slot = !stat_i.div_busy;
      end
      pbm_pkg::S_FLUSH_PRE: begin
        cmd_o.emit         = stat_i.out_space;
        cmd_o.finish_flush = stat_i.out_space && stat_i.idx_last;
      end
      pbm_pkg::S_PLACE: begin
        cmd_o.place = 1'b1;
      end
      pbm_pkg::S_FLUSH_END: begin
        cmd_o.flush_end    = 1'b1;
        cmd_o.emit         = !stat_i.count_zero && stat_i.out_space;
        cmd_o.finish_flush = !stat_i.count_zero && stat_i.out_space && stat_i.idx_last;
        cmd_o.close_bin    = stat_i.count_zero || (stat_i.out_space && stat_i.idx_last);
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/pbm_dpath.sv
// Datapath: configuration registers, input latch, divider, per-slot store,
// order list and output register. Depends on pbm_pkg and pbm_div.
module pbm_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pbm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pbm_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  input  pbm_pkg::peak_in_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pbm_pkg::bin_out_t                 out_data_o,
  input  pbm_pkg::cmd_t                     cmd_i,
  output pbm_pkg::stat_t                    stat_o
);

  localparam int unsigned SW = pbm_pkg::SLOT_W;
  localparam int unsigned CW = pbm_pkg::COUNT_W;

  // configuration
  logic [31:0] mz_lower_q, mz_upper_q, mz_bw_q;
  logic [17:0] im_lower_q, im_upper_q, im_bw_q;
  logic [5:0]  im_count_q;
  logic        use_im_q;

  pbm_pkg::peak_in_t pk_q;

  logic [31:0] bin_q, cur_bin_q, slot_q;
  logic [15:0] off_q;
  logic        bin_open_q;

  logic [pbm_pkg::IM_BINS-1:0] slot_valid_q;
  logic [31:0] best_q  [pbm_pkg::IM_BINS];
  logic [15:0] soff_q  [pbm_pkg::IM_BINS];
  logic [23:0] sspec_q [pbm_pkg::IM_BINS];
  logic [7:0]  schg_q  [pbm_pkg::IM_BINS];
  logic [SW-1:0] order_q [pbm_pkg::IM_BINS];
  logic [CW-1:0] count_q;
  logic [SW-1:0] idx_q;

  pbm_pkg::bin_out_t out_q;
  logic              out_valid_q;

  // divider hookup
  logic                       div_start, div_busy;
  logic [31:0]                div_init, div_dvd, div_dsr, div_quo, div_rem;
  logic [pbm_pkg::STEP_W-1:0] div_steps;
  logic [31:0]                mz_w;
  logic [17:0]                im_w, im_d;
  logic [47:0]                scaled;

  assign mz_w   = (mz_bw_q == '0) ? 32'd1 : mz_bw_q;
  assign im_w   = (im_bw_q == '0) ? 18'd1 : im_bw_q;
  assign im_d   = pk_q.ion_mobility - im_lower_q;
  // remainder times 65535
  assign scaled = {div_rem, 16'h0000} - {16'h0000, div_rem};

  always_comb begin
    div_start = cmd_i.start_mz || cmd_i.start_off || cmd_i.start_im;
    div_init  = '0;
    div_dvd   = pk_q.mz - mz_lower_q;
    div_dsr   = mz_w;
    div_steps = pbm_pkg::STEP_W'(32);
    if (cmd_i.start_off) begin
      div_init  = scaled[47:16];
      div_dvd   = {scaled[15:0], 16'h0000};
      div_steps = pbm_pkg::STEP_W'(16);
    end else if (cmd_i.start_im) begin
      div_dvd   = {im_d, 14'h0000};
      div_dsr   = {14'h0000, im_w};
      div_steps = pbm_pkg::STEP_W'(18);
    end
  end

  pbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_init),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // status
  logic [SW-1:0] pslot, fslot;
  logic          idx_last, out_space;

  assign pslot     = slot_q[SW-1:0];
  assign fslot     = order_q[idx_q];
  assign idx_last  = {1'b0, idx_q} == CW'(count_q - 1'b1);
  assign out_space = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o            = '0;
    stat_o.mz_ok      = pk_q.peak_present && (pk_q.mz >= mz_lower_q) && (pk_q.mz < mz_upper_q);
    stat_o.im_ok      = !use_im_q ||
                        ((pk_q.ion_mobility >= im_lower_q) && (pk_q.ion_mobility < im_upper_q));
    stat_o.use_im     = use_im_q;
    stat_o.div_busy   = div_busy;
    stat_o.slot_ok    = !use_im_q ||
                        ((slot_q < {26'h0, im_count_q}) && (slot_q < pbm_pkg::IM_BINS));
    stat_o.need_pre   = bin_open_q && (bin_q != cur_bin_q) && (count_q != '0);
    stat_o.count_zero = count_q == '0;
    stat_o.idx_last   = idx_last;
    stat_o.out_space  = out_space;
    stat_o.end_flag   = pk_q.spectrum_end;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mz_lower_q <= 32'd26214400;
      mz_upper_q <= 32'd131072000;
      mz_bw_q    <= 32'd6554;
      im_lower_q <= 18'd39322;
      im_upper_q <= 18'd111411;
      im_bw_q    <= 18'd655;
      im_count_q <= 6'd32;
      use_im_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (pbm_pkg::cfg_reg_e'(cfg_idx_i))
        pbm_pkg::REG_MZ_LOWER:     mz_lower_q <= cfg_data_i;
        pbm_pkg::REG_MZ_UPPER:     mz_upper_q <= cfg_data_i;
        pbm_pkg::REG_MZ_BIN_WIDTH: mz_bw_q    <= cfg_data_i;
        pbm_pkg::REG_IM_LOWER:     im_lower_q <= cfg_data_i[17:0];
        pbm_pkg::REG_IM_UPPER:     im_upper_q <= cfg_data_i[17:0];
        pbm_pkg::REG_IM_BIN_WIDTH: im_bw_q    <= cfg_data_i[17:0];
        pbm_pkg::REG_IM_BIN_COUNT: im_count_q <= cfg_data_i[5:0];
        pbm_pkg::REG_USE_IM:       use_im_q   <= cfg_data_i[0];
        default:                   use_im_q   <= use_im_q;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) pk_q <= in_data_i;
    if (cmd_i.cap_bin)  bin_q <= div_quo;
    if (cmd_i.cap_off) begin
      off_q  <= div_quo[15:0];
      slot_q <= '0;
    end
    if (cmd_i.cap_slot) slot_q <= div_quo;
    if (cmd_i.place) begin
      if (!slot_valid_q[pslot]) begin
        best_q[pslot]  <= pk_q.intensity;
        soff_q[pslot]  <= off_q;
        sspec_q[pslot] <= pk_q.spectrum_tag;
        schg_q[pslot]  <= pk_q.charge;
        if (count_q < CW'(pbm_pkg::IM_BINS)) order_q[count_q[SW-1:0]] <= pslot;
      end else if (pk_q.intensity > best_q[pslot]) begin
        best_q[pslot] <= pk_q.intensity;
        soff_q[pslot] <= off_q;
      end
    end
    if (cmd_i.emit) begin
      out_q.flat_bin       <= use_im_q ? 32'(cur_bin_q * im_count_q + {26'h0, fslot})
                                       : cur_bin_q;
      out_q.entry_spectrum <= sspec_q[fslot];
      out_q.bin_offset     <= soff_q[fslot];
      out_q.entry_charge   <= schg_q[fslot];
      out_q.last_of_run    <= idx_last && (cmd_i.flush_end || !pk_q.spectrum_end);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_bin_q    <= '0;
      bin_open_q   <= 1'b0;
      slot_valid_q <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.emit)          out_valid_q <= 1'b1;
      else if (out_ready_i)    out_valid_q <= 1'b0;
      if (cmd_i.place) begin
        cur_bin_q  <= bin_q;
        bin_open_q <= 1'b1;
        if (!slot_valid_q[pslot]) begin
          slot_valid_q[pslot] <= 1'b1;
          if (count_q < CW'(pbm_pkg::IM_BINS)) count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.emit) slot_valid_q[fslot] <= 1'b0;
      // hold the order list empty once the last entry has gone out
      if (cmd_i.finish_flush) begin
        count_q <= '0;
        idx_q   <= '0;
      end else if (cmd_i.emit) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.close_bin) bin_open_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(pbm_pkg::IM_BINS))
    else $error("occupied count past slot limit");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> count_q != '0)
    else $error("flush emitted with no occupied slot");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish_flush |=> (count_q == '0) && (idx_q == '0))
    else $error("order list not cleared after flush");

  a_place_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |=> slot_valid_q[$past(pslot)])
    else $error("placed slot not marked valid");

endmodule

FILE: src/peak_bin_max_picker.sv
// Peak bin max picker: per m/z bin (and IM slot) keeps the most intense peak.
// A peak out of range or a bare end mark skips the divider. A kept 1D peak runs the
// one-bit-per-cycle divider for its m/z bin (32 steps) and offset (16 steps); in IM mode
// (also for an IM peak dropped on the slot limit) an 18-step slot division follows.
// A flush sends out one entry per cycle unless the output stalls.
// Reset clears control state and loads register defaults; slot data is unreset.
module peak_bin_max_picker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pbm_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pbm_pkg::peak_in_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pbm_pkg::bin_out_t             out_data_o
);

  pbm_pkg::cmd_t  cmd;
  pbm_pkg::stat_t stat;

  pbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pbm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

FILE: tb/sv/tb_peak_bin_max_picker.sv
// Testbench for peak_bin_max_picker: directed and random peak streams, with a
// behavioural bin/slot predictor and an in-order checker on the result channel.
// Depends on pbm_pkg and the peak_bin_max_picker RTL.
`timescale 1ns / 100ps

module tb_peak_bin_max_picker;

  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pbm_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [pbm_pkg::CFG_DAT_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pbm_pkg::peak_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pbm_pkg::bin_out_t out_data_o;

  peak_bin_max_picker DUT (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers and bin state
  logic [31:0] mz_lo, mz_hi, mz_w;
  logic [17:0] im_lo, im_hi, im_w;
  logic [5:0]  im_cnt;
  logic        im_mode;
  logic [31:0] open_bin;
  logic        open_flag;
  logic        occ     [pbm_pkg::IM_BINS];
  logic [31:0] best_int[pbm_pkg::IM_BINS];
  logic [15:0] best_off[pbm_pkg::IM_BINS];
  logic [23:0] first_spec[pbm_pkg::IM_BINS];
  logic [7:0]  first_chg[pbm_pkg::IM_BINS];
  int unsigned use_order[$];

  pbm_pkg::bin_out_t expected_bins[$];
  int unsigned errors = 0, peaks_sent = 0, bins_seen = 0, idle_cycles = 0;
  bit stall_enable = 1'b1;

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    errors++;
  endtask

  function automatic void predictor_reset();
    mz_lo = 32'd26214400; mz_hi = 32'd131072000; mz_w = 32'd6554;
    im_lo = 18'd39322; im_hi = 18'd111411; im_w = 18'd655;
    im_cnt = 6'd32; im_mode = 1'b0;
    open_bin = '0; open_flag = 1'b0;
    foreach (occ[i]) occ[i] = 1'b0;
    use_order.delete();
  endfunction

  function automatic void flush_open_bin(inout int produced);
    pbm_pkg::bin_out_t r;
    foreach (use_order[i]) begin
      r.flat_bin       = im_mode ? 32'(open_bin * im_cnt + use_order[i]) : open_bin;
      r.entry_spectrum = first_spec[use_order[i]];
      r.bin_offset     = best_off[use_order[i]];
      r.entry_charge   = first_chg[use_order[i]];
      r.last_of_run    = 1'b0;
      occ[use_order[i]] = 1'b0;
      expected_bins = {expected_bins, r};
      produced++;
    end
    use_order.delete();
  endfunction

  function automatic void predict_peak(input pbm_pkg::peak_in_t p);
    int produced = 0;
    logic [31:0] w, d, bin, rem;
    logic [63:0] off;
    logic [17:0] iw;
    int unsigned slot = 0;
    bit keep = 1'b1;
    if (p.peak_present && p.mz >= mz_lo && p.mz < mz_hi) begin
      w = (mz_w == 0) ? 32'd1 : mz_w;
      d = p.mz - mz_lo;
      bin = d / w;
      rem = d % w;
      off = (64'(rem) * 64'd65535) / 64'(w);
      if (off > 64'd65535) off = 64'd65535;
      if (im_mode) begin
        iw = (im_w == 0) ? 18'd1 : im_w;
        if (p.ion_mobility < im_lo || p.ion_mobility >= im_hi) keep = 1'b0;
        else begin
          slot = (p.ion_mobility - im_lo) / iw;
          if (slot >= im_cnt || slot >= pbm_pkg::IM_BINS) keep = 1'b0;
        end
      end
      if (keep) begin
        if (open_flag && bin != open_bin) flush_open_bin(produced);
        open_bin = bin;
        open_flag = 1'b1;
        if (!occ[slot]) begin
          occ[slot] = 1'b1;
          use_order = {use_order, slot};
          best_int[slot] = p.intensity;
          best_off[slot] = off[15:0];
          first_spec[slot] = p.spectrum_tag;
          first_chg[slot] = p.charge;
        end else if (p.intensity > best_int[slot]) begin
          best_int[slot] = p.intensity;
          best_off[slot] = off[15:0];
        end
      end
    end
    if (p.spectrum_end) begin
      flush_open_bin(produced);
      open_flag = 1'b0;
    end
    if (produced > 0) expected_bins[$].last_of_run = 1'b1;
  endfunction

  task automatic send_peak(input pbm_pkg::peak_in_t p);
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    predict_peak(p);
    peaks_sent++;
    in_valid_i <= 1'b0;
    // leave the accepting edge before the next drive
    @(posedge clk_i);
  endtask

  // bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  task automatic send_paced(input pbm_pkg::peak_in_t p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
    end
    burst_left--;
    send_peak(p);
  endtask

  task automatic drain();
    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input pbm_pkg::cfg_reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pbm_pkg::REG_MZ_LOWER:     mz_lo = val;
      pbm_pkg::REG_MZ_UPPER:     mz_hi = val;
      pbm_pkg::REG_MZ_BIN_WIDTH: mz_w = val;
      pbm_pkg::REG_IM_LOWER:     im_lo = val[17:0];
      pbm_pkg::REG_IM_UPPER:     im_hi = val[17:0];
      pbm_pkg::REG_IM_BIN_WIDTH: im_w = val[17:0];
      pbm_pkg::REG_IM_BIN_COUNT: im_cnt = val[5:0];
      pbm_pkg::REG_USE_IM:       im_mode = val[0];
      default: ;
    endcase
  endtask

  function automatic pbm_pkg::peak_in_t make_peak(input logic [31:0] mz,
                                                  input logic [17:0] im, input bit endm);
    pbm_pkg::peak_in_t p;
    p.spectrum_tag = 24'($urandom);
    p.charge       = 8'($urandom);
    p.mz           = mz;
    p.intensity    = $urandom;
    p.ion_mobility = im;
    p.peak_present = 1'b1;
    p.spectrum_end = endm;
    return p;
  endfunction

  // receiver: stall pattern of its own, with stall-free stretches
  always @(posedge clk_i) begin
    if (stall_enable && $urandom_range(0, 3) == 0) out_ready_i <= 1'b0;
    else if (!stall_enable) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 4) != 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      bins_seen++;
      if (expected_bins.size() == 0) report_mismatch("unexpected result transaction");
      else begin
        pbm_pkg::bin_out_t e;
        e = expected_bins.pop_front();
        if (out_data_o.flat_bin != e.flat_bin)
          report_mismatch($sformatf("flat_bin %0d exp %0d", out_data_o.flat_bin, e.flat_bin));
        if (out_data_o.entry_spectrum != e.entry_spectrum)
          report_mismatch($sformatf("entry_spectrum %h exp %h",
                                    out_data_o.entry_spectrum, e.entry_spectrum));
        if (out_data_o.bin_offset != e.bin_offset)
          report_mismatch($sformatf("bin_offset %0d exp %0d",
                                    out_data_o.bin_offset, e.bin_offset));
        if (out_data_o.entry_charge != e.entry_charge)
          report_mismatch($sformatf("entry_charge %0d exp %0d",
                                    out_data_o.entry_charge, e.entry_charge));
        if (out_data_o.last_of_run != e.last_of_run)
          report_mismatch($sformatf("last_of_run %0b exp %0b",
                                    out_data_o.last_of_run, e.last_of_run));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_bins.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed_1d();
    pbm_pkg::peak_in_t p;
    p = make_peak(32'd26214400, '0, 1'b0); send_peak(p);          // lowest in range
    p = make_peak(32'd26214400 + 100, '0, 1'b0); p.intensity = p.intensity; send_peak(p);
    p = make_peak(32'd26214400 + 100, '0, 1'b0); p.intensity = '1; send_peak(p); // max wins
    p = make_peak(32'd26214400 + 200, '0, 1'b0); p.intensity = '1; send_peak(p); // tie holds
    p = make_peak(32'd26214399, '0, 1'b0); send_peak(p);          // below range
    p = make_peak(32'd131072000, '0, 1'b0); send_peak(p);         // upper excluded
    p = make_peak(32'd131071999, '1, 1'b0); send_peak(p);         // new bin flushes
    p = make_peak(32'd26220000, '0, 1'b0); send_peak(p);          // downward bin change
    p = make_peak('1, '0, 1'b0); p.peak_present = 1'b0; p.spectrum_end = 1'b1;
    send_peak(p);                                                  // bare end mark
    send_peak(p);                                                  // end with nothing open
    p = make_peak(32'd30000000, '0, 1'b1); p.intensity = '0; send_peak(p);
    drain();
  endtask

  task automatic test_directed_im();
    pbm_pkg::peak_in_t p;
    write_reg(pbm_pkg::REG_USE_IM, 32'd1);
    write_reg(pbm_pkg::REG_IM_LOWER, 32'd1000);
    write_reg(pbm_pkg::REG_IM_UPPER, 32'h3ffff);
    write_reg(pbm_pkg::REG_IM_BIN_WIDTH, 32'd100);
    write_reg(pbm_pkg::REG_IM_BIN_COUNT, 32'd32);
    p = make_peak(32'd40000000, 18'd999, 1'b0); send_peak(p);     // below IM range
    p = make_peak(32'd40000000, 18'd1000, 1'b0); send_peak(p);
    p = make_peak(32'd40000000, 18'd4199, 1'b0); send_peak(p);    // slot 31
    p = make_peak(32'd40000000, 18'd4200, 1'b0); send_peak(p);    // slot 32 dropped
    p = make_peak(32'd40000000, 18'h3ffff, 1'b0); send_peak(p);   // upper excluded
    p = make_peak(32'd40000001, 18'd1500, 1'b1); send_peak(p);
    drain();
    write_reg(pbm_pkg::REG_IM_BIN_COUNT, 32'd0);                    // drops every peak
    p = make_peak(32'd40000000, 18'd1000, 1'b1); send_peak(p);
    drain();
    write_reg(pbm_pkg::REG_IM_BIN_COUNT, 32'd63);
    write_reg(pbm_pkg::REG_IM_BIN_WIDTH, 32'd0);                    // acts as one
    write_reg(pbm_pkg::REG_MZ_BIN_WIDTH, 32'd0);
    p = make_peak(32'd26214400 + 7, 18'd1005, 1'b0); send_peak(p);
    p = make_peak(32'd26214400 + 7, 18'd1040, 1'b1); send_peak(p);
    drain();
  endtask

  // spectra of mostly ascending m/z with occasional noise, a few peaks per bin, random IM
  task automatic run_spectra(input int unsigned n_items);
    pbm_pkg::peak_in_t p;
    logic [31:0] mz;
    int unsigned k = 0;
    while (k < n_items) begin
      mz = mz_lo + $urandom_range(0, 2000);
      repeat ($urandom_range(2, 12)) begin
        if ($urandom_range(0, 9) == 0) mz = $urandom;               // noise or out of order
        else mz = mz + $urandom_range(0, 3) * (mz_w == 0 ? 1 : mz_w) / 2;
        p = make_peak(mz, 18'(im_lo + $urandom_range(0, 40) * (im_w == 0 ? 1 : im_w) / 4),
                      1'b0);
        if ($urandom_range(0, 7) == 0) p.ion_mobility = 18'($urandom);
        if ($urandom_range(0, 9) == 0) p.peak_present = 1'b0;
        if ($urandom_range(0, 4) == 0) p.intensity = $urandom_range(0, 3);
        send_paced(p);
        k++;
      end
      p = make_peak($urandom, 18'($urandom), 1'b1);
      p.peak_present = 1'($urandom_range(0, 1));
      send_paced(p);
      k++;
    end
  endtask

  task automatic test_random_1d();
    write_reg(pbm_pkg::REG_USE_IM, 32'd0);
    write_reg(pbm_pkg::REG_MZ_LOWER, 32'd0);
    write_reg(pbm_pkg::REG_MZ_UPPER, 32'hffffffff);
    write_reg(pbm_pkg::REG_MZ_BIN_WIDTH, 32'd6554);
    run_spectra(22);
    drain();                                                        // sender holds off here
    write_reg(pbm_pkg::REG_MZ_BIN_WIDTH, 32'hffffffff);
    run_spectra(8);
    drain();
  endtask

  task automatic test_random_im();
    write_reg(pbm_pkg::REG_MZ_LOWER, 32'd26214400);
    write_reg(pbm_pkg::REG_MZ_UPPER, 32'd131072000);
    write_reg(pbm_pkg::REG_MZ_BIN_WIDTH, 32'd1311);
    write_reg(pbm_pkg::REG_IM_LOWER, 32'd39322);
    write_reg(pbm_pkg::REG_IM_UPPER, 32'd111411);
    write_reg(pbm_pkg::REG_IM_BIN_WIDTH, 32'd655);
    write_reg(pbm_pkg::REG_IM_BIN_COUNT, 32'd7);
    write_reg(pbm_pkg::REG_USE_IM, 32'd1);
    stall_enable = 1'b0;
    run_spectra(22);
    drain();
    stall_enable = 1'b1;
    write_reg(pbm_pkg::REG_IM_BIN_COUNT, 32'd32);
    write_reg(pbm_pkg::REG_IM_LOWER, 32'd0);
    write_reg(pbm_pkg::REG_IM_UPPER, 32'h3ffff);
    run_spectra(22);
    drain();
  endtask

  initial begin
    predictor_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_1d();
    test_directed_im();
    test_random_1d();
    test_random_im();
    $display("Sent %0d peak transactions in 1D and IM modes, checked %0d bin entries.",
             peaks_sent, bins_seen);
    if (errors == 0 && expected_bins.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
src/pbm_pkg.sv
src/pbm_div.sv
src/pbm_ctrl.sv
src/pbm_dpath.sv
src/peak_bin_max_picker.sv
tb/sv/tb_peak_bin_max_picker.sv
